// ----- sv/aavr_pkg.sv -----
// aavr_pkg: shared types, widths and constants for the axis-angle rotator
// used by aavr_cordic and axis_angle_vector_rotate_top; depends on nothing

package aavr_pkg;

   // field widths
   localparam int COORD_WIDTH = 24;
   localparam int AXIS_WIDTH  = 16;
   localparam int ANGLE_WIDTH = 16;
   localparam int TRIG_BITS   = 16;

   // cordic datapath, Q30 with headroom
   localparam int CORDIC_W   = 34;
   localparam int TRIG_W     = TRIG_BITS + 2;
   localparam int CORDIC_LAT = TRIG_BITS + 2;

   // matrix datapath widths
   localparam int UU_W   = 2 * AXIS_WIDTH;
   localparam int OMC_W  = TRIG_W + 1;
   localparam int US_W   = AXIS_WIDTH + TRIG_W;
   localparam int MAT_W  = TRIG_BITS + 36;
   localparam int ENT_W  = MAT_W - 28;
   localparam int PROD_W = ENT_W + COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W - TRIG_BITS;

   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [31:0]         PI_Q29       = 32'sd1686629713;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic signed [AXIS_WIDTH-1:0]  axis_x;
      logic signed [AXIS_WIDTH-1:0]  axis_y;
      logic signed [AXIS_WIDTH-1:0]  axis_z;
      logic signed [ANGLE_WIDTH-1:0] turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
      logic signed [COORD_WIDTH-1:0] rotated_z;
      logic                          saturated;
   } rsp_type;

   // pipeline control shared by the stages
   typedef struct packed {
      logic advance;
   } pipe_ctrl_type;

   // atan(2^-i) in Q30
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
      logic signed [CORDIC_W-1:0] r;
      unique case (i)
         0:  r = 34'sd843314857;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043837;
         3:  r = 34'sd133525159;
         4:  r = 34'sd67021687;
         5:  r = 34'sd33543516;
         6:  r = 34'sd16775851;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194283;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048576;
         11: r = 34'sd524288;
         12: r = 34'sd262144;
         13: r = 34'sd131072;
         14: r = 34'sd65536;
         15: r = 34'sd32768;
         16: r = 34'sd16384;
         17: r = 34'sd8192;
         18: r = 34'sd4096;
         19: r = 34'sd2048;
         20: r = 34'sd1024;
         21: r = 34'sd512;
         22: r = 34'sd256;
         23: r = 34'sd128;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/aavr_cordic.sv -----
// aavr_cordic: pipelined cosine and sine of the negated binary angle
// one cordic iteration per stage; depends on aavr_pkg

module aavr_cordic (
   input  logic                                 clock,
   input  aavr_pkg::pipe_ctrl_type              ctrl,
   input  logic signed [aavr_pkg::ANGLE_WIDTH-1:0] angle,
   output logic signed [aavr_pkg::TRIG_W-1:0]   cos_q,
   output logic signed [aavr_pkg::TRIG_W-1:0]   sin_q
);

   localparam int TB = aavr_pkg::TRIG_BITS;
   localparam int CW = aavr_pkg::CORDIC_W;
   localparam int PW = 49;
   localparam logic signed [CW-1:0] RND_HALF = CW'(1) <<< (29 - TB);

   logic signed [CW-1:0] x_ff [TB];
   logic signed [CW-1:0] y_ff [TB];
   logic signed [CW-1:0] z_ff [TB+1];
   logic                 flip_ff [TB+1];
   logic signed [aavr_pkg::TRIG_W-1:0] cos_ff, sin_ff;

   logic signed [aavr_pkg::ANGLE_WIDTH-1:0] neg_ang;
   logic signed [16:0]                      fold_ang;
   logic                                    flip_in;
   logic signed [PW-1:0]                    rad_prod;
   logic signed [CW-1:0]                    z0_in;
   logic signed [CW-1:0]                    xr, yr;
   logic signed [aavr_pkg::TRIG_W-1:0]      cr, sr;

   // negate, fold into a half turn, convert to Q30 radians
   always_comb begin
      neg_ang  = aavr_pkg::ANGLE_WIDTH'(-angle);
      fold_ang = 17'(neg_ang);
      flip_in  = 1'b0;
      if (fold_ang > 17'sd16384) begin
         fold_ang = fold_ang - 17'sd32768;
         flip_in  = 1'b1;
      end else if (fold_ang < -17'sd16384) begin
         fold_ang = fold_ang + 17'sd32768;
         flip_in  = 1'b1;
      end
      rad_prod = fold_ang * aavr_pkg::PI_Q29;
      z0_in    = CW'((rad_prod + 49'sd8192) >>> 14);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         z_ff[0]    <= z0_in;
         flip_ff[0] <= flip_in;
      end
   end

   // rotation iterations
   for (genvar i = 0; i < TB; i++) begin : g_iter
      logic signed [CW-1:0] xp, yp, x_in, y_in, z_in;
      always_comb begin
         if (i == 0) begin
            xp = aavr_pkg::CORDIC_START;
            yp = '0;
         end else begin
            xp = x_ff[(i == 0) ? 0 : i-1];
            yp = y_ff[(i == 0) ? 0 : i-1];
         end
         if (!z_ff[i][CW-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = z_ff[i] - aavr_pkg::atan_q30(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = z_ff[i] + aavr_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            x_ff[i]      <= x_in;
            y_ff[i]      <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // round to Q(TRIG_BITS) and undo the fold
   always_comb begin
      xr = (x_ff[TB-1] + RND_HALF) >>> (30 - TB);
      yr = (y_ff[TB-1] + RND_HALF) >>> (30 - TB);
      cr = aavr_pkg::TRIG_W'(xr);
      sr = aavr_pkg::TRIG_W'(yr);
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         cos_ff <= flip_ff[TB] ? -cr : cr;
         sin_ff <= flip_ff[TB] ? -sr : sr;
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

// ----- sv/axis_angle_vector_rotate_top.sv -----
// Rotates a Q15.8 point clockwise about a unit Q1.14 axis by a binary angle
// using the Rodrigues matrix and a pipelined cordic; one word per cycle, with
// one cordic iteration per stage plus five matrix stages; the whole pipeline
// holds while the result is not taken. Depends on aavr_pkg and aavr_cordic.

module axis_angle_vector_rotate_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aavr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aavr_pkg::rsp_type rsp_data
);

   localparam int LAT = aavr_pkg::CORDIC_LAT;
   localparam int CWD = aavr_pkg::COORD_WIDTH;
   localparam int AW  = aavr_pkg::AXIS_WIDTH;
   localparam int TB  = aavr_pkg::TRIG_BITS;
   localparam logic signed [aavr_pkg::MAT_W-1:0] ENT_HALF =
      aavr_pkg::MAT_W'(1) <<< 27;
   localparam logic signed [aavr_pkg::SUM_W-1:0] OUT_HALF =
      aavr_pkg::SUM_W'(1) <<< (TB - 1);
   localparam logic signed [aavr_pkg::OMC_W-1:0] ONE_Q =
      aavr_pkg::OMC_W'(1) <<< TB;
   localparam logic signed [aavr_pkg::RND_W-1:0] HI_LIM =
      aavr_pkg::RND_W'((64'sd1 <<< (CWD - 1)) - 64'sd1);
   localparam logic signed [aavr_pkg::RND_W-1:0] LO_LIM =
      aavr_pkg::RND_W'(-(64'sd1 <<< (CWD - 1)));

   aavr_pkg::pipe_ctrl_type ctrl;
   logic rsp_valid_ff;
   aavr_pkg::rsp_type rsp_ff, rsp_in;

   // pipeline moves when the output register is free
   assign ctrl.advance = !rsp_valid_ff || rsp_ready;
   assign req_ready    = ctrl.advance;

   // trig unit
   logic signed [aavr_pkg::TRIG_W-1:0] cos_q, sin_q;
   aavr_cordic u_cordic (
      .clock (clock),
      .ctrl  (ctrl),
      .angle (req_data.turn_angle),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   // point and axis wait alongside the cordic
   logic                  v_dly_ff [LAT];
   logic signed [CWD-1:0] p_dly_ff [LAT][3];
   logic signed [AW-1:0]  u_dly_ff [LAT][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) v_dly_ff[k] <= 1'b0;
      end else if (ctrl.advance) begin
         v_dly_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) v_dly_ff[k] <= v_dly_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         p_dly_ff[0][0] <= req_data.point_x;
         p_dly_ff[0][1] <= req_data.point_y;
         p_dly_ff[0][2] <= req_data.point_z;
         u_dly_ff[0][0] <= req_data.axis_x;
         u_dly_ff[0][1] <= req_data.axis_y;
         u_dly_ff[0][2] <= req_data.axis_z;
         for (int k = 1; k < LAT; k++) begin
            p_dly_ff[k] <= p_dly_ff[k-1];
            u_dly_ff[k] <= u_dly_ff[k-1];
         end
      end
   end

   // stage a: axis outer product, trig captured
   logic                                va_ff;
   logic signed [aavr_pkg::UU_W-1:0]    uu_ff [3][3];
   logic signed [aavr_pkg::TRIG_W-1:0]  ca_ff, sa_ff;
   logic signed [AW-1:0]                ua_ff [3];
   logic signed [CWD-1:0]               pa_ff [3];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               uu_ff[r][k] <= u_dly_ff[LAT-1][r] * u_dly_ff[LAT-1][k];
         ca_ff <= cos_q;
         sa_ff <= sin_q;
         ua_ff <= u_dly_ff[LAT-1];
         pa_ff <= p_dly_ff[LAT-1];
      end
   end

   // stage b: scale by one minus cosine, axis times sine
   logic                                va_dummy;
   logic                                vb_ff;
   logic signed [aavr_pkg::MAT_W-1:0]   uuo_ff [3][3];
   logic signed [aavr_pkg::US_W-1:0]    us_ff [3];
   logic signed [aavr_pkg::TRIG_W-1:0]  cb_ff;
   logic signed [CWD-1:0]               pb_ff [3];
   logic signed [aavr_pkg::OMC_W-1:0]   omc;

   assign omc      = ONE_Q - aavr_pkg::OMC_W'(ca_ff);
   assign va_dummy = va_ff;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) uuo_ff[r][k] <= uu_ff[r][k] * omc;
            us_ff[r] <= ua_ff[r] * sa_ff;
         end
         cb_ff <= ca_ff;
         pb_ff <= pa_ff;
      end
   end

   // stage c: matrix entries rounded to Q(TRIG_BITS)
   logic                                vc_ff;
   logic signed [aavr_pkg::ENT_W-1:0]   ent_ff [3][3];
   logic signed [CWD-1:0]               pc_ff [3];
   logic signed [aavr_pkg::ENT_W-1:0]   ent_in [3][3];

   always_comb begin
      logic signed [aavr_pkg::MAT_W-1:0] acc;
      logic signed [aavr_pkg::MAT_W-1:0] cterm;
      logic signed [aavr_pkg::MAT_W-1:0] sterm;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            cterm = aavr_pkg::MAT_W'(cb_ff) <<< 28;
            sterm = aavr_pkg::MAT_W'(us_ff[3 - r - k > 2 ? 0 : 3 - r - k]) <<< 14;
            acc   = uuo_ff[r][k];
            if (r == k) acc = acc + cterm;
            else if (k == (r + 2) % 3) acc = acc + sterm;
            else acc = acc - sterm;
            ent_in[r][k] = aavr_pkg::ENT_W'((acc + ENT_HALF) >>> 28);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         ent_ff <= ent_in;
         pc_ff  <= pb_ff;
      end
   end

   // stage d: entry times coordinate
   logic                                vd_ff;
   logic signed [aavr_pkg::PROD_W-1:0]  prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               prod_ff[r][k] <= ent_ff[r][k] * pc_ff[k];
      end
   end

   // stage e: row sums, rounding and saturation into the output register
   logic signed [CWD-1:0] res [3];
   logic                  sat [3];

   always_comb begin
      logic signed [aavr_pkg::SUM_W-1:0] sum;
      logic signed [aavr_pkg::RND_W-1:0] rnd;
      for (int r = 0; r < 3; r++) begin
         sum = aavr_pkg::SUM_W'(prod_ff[r][0]) + aavr_pkg::SUM_W'(prod_ff[r][1])
             + aavr_pkg::SUM_W'(prod_ff[r][2]);
         rnd = aavr_pkg::RND_W'((sum + OUT_HALF) >>> TB);
         sat[r] = 1'b1;
         if (rnd > HI_LIM)      res[r] = CWD'(HI_LIM);
         else if (rnd < LO_LIM) res[r] = CWD'(LO_LIM);
         else begin
            res[r] = CWD'(rnd);
            sat[r] = 1'b0;
         end
      end
      rsp_in.rotated_x = res[0];
      rsp_in.rotated_y = res[1];
      rsp_in.rotated_z = res[2];
      rsp_in.saturated = sat[0] | sat[1] | sat[2];
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) rsp_ff <= rsp_in;
   end

   // valid bits of the matrix stages
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         va_ff        <= v_dly_ff[LAT-1];
         vb_ff        <= va_dummy;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         rsp_valid_ff <= vd_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the output register");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.rotated_x == CWD'(HI_LIM) || rsp_data.rotated_x == CWD'(LO_LIM) ||
         rsp_data.rotated_y == CWD'(HI_LIM) || rsp_data.rotated_y == CWD'(LO_LIM) ||
         rsp_data.rotated_z == CWD'(HI_LIM) || rsp_data.rotated_z == CWD'(LO_LIM))
      else $error("saturation flagged with no component at a limit");

endmodule
